// ----- rtl/clir_pkg.sv -----
// Shared constants, command and status types for the complex linear interpolation resampler.
// Used by the MAC, divider and top modules of the block; depends on nothing else.
`default_nettype none

package clir_pkg;

    // Item field widths
    localparam int FREQ_W        = 32;
    localparam int VAL_W         = 16;
    localparam int COUNT_W       = 16;
    localparam int NEXT_W        = FREQ_W + 1;

    // Complex parameters per source point and the real values they carry
    localparam int PARAM_COUNT   = 4;
    localparam int NUM_VALUES    = 8;
    localparam int ACTIVE_VALUES = 2 * PARAM_COUNT;
    localparam int VIDX_W        = $clog2(NUM_VALUES);

    // Results per item
    localparam int MAX_RESULTS   = 64;
    localparam int RES_W         = $clog2(MAX_RESULTS + 1);

    // Configuration port
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 32;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STEP  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STOP  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_COUNT = CFG_IDX_W'(3);

    localparam logic [FREQ_W-1:0]  RST_SWEEP_START = '0;
    localparam logic [FREQ_W-1:0]  RST_SWEEP_STEP  = FREQ_W'(1);
    localparam logic [FREQ_W-1:0]  RST_SWEEP_STOP  = '1;
    localparam logic [COUNT_W-1:0] RST_SWEEP_COUNT = COUNT_W'(1601);

    // Sweep position saturates one past the last 32-bit frequency
    localparam logic [NEXT_W-1:0] SWEEP_END = {1'b1, {FREQ_W{1'b0}}};

    // Saturation limits of a Q1.15 result
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Shared multiplier: value (or count) times frequency difference (or step)
    localparam int MUL_A_W = VAL_W + 1;
    localparam int MUL_B_W = FREQ_W + 1;
    localparam int ACC_W   = MUL_A_W + MUL_B_W;

    // Shared divider: quotient bits before saturation is declared
    localparam int QUOT_W    = VAL_W + 1;
    localparam int DVS_W     = FREQ_W;
    localparam int DVD_W     = ACC_W;
    localparam int DREM_W    = DVS_W + QUOT_W;
    localparam int DSH_W     = DREM_W - 1;
    localparam int DIV_CNT_W = $clog2(QUOT_W + 1);

    typedef struct packed {
        logic               en;
        logic               acc_en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mac_op_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [QUOT_W-1:0] quot;
    } div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/clir_mac.sv -----
// Shared signed multiply-accumulate unit with a registered result.
// Depends on clir_pkg for the operand and accumulator widths.
`default_nettype none

module clir_mac (
    input  wire logic                         clk,
    input  wire clir_pkg::mac_op_t            op,
    output logic signed [clir_pkg::ACC_W-1:0] acc
);

    logic signed [clir_pkg::ACC_W-1:0] acc_reg;
    logic signed [clir_pkg::ACC_W-1:0] acc_next;
    logic signed [clir_pkg::ACC_W-1:0] product;

    // Multiply, then either load or add to the running sum
    always_comb
    begin
        product  = $signed(op.a) * $signed(op.b);
        acc_next = op.acc_en ? (acc_reg + product) : product;
    end

    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ----- rtl/clir_div.sv -----
// Shared restoring divider, one quotient bit per cycle, with early saturation detect.
// Depends on clir_pkg for the command and status structs.
`default_nettype none

module clir_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire clir_pkg::div_cmd_t   cmd,
    output clir_pkg::div_stat_t       stat
);

    typedef enum logic [2:0] {
        D_IDLE  = 3'b001,
        D_CHECK = 3'b010,
        D_RUN   = 3'b100
    } dstate_t;

    dstate_t                            state_reg, state_next;
    logic                               done_reg, done_next;
    logic                               sat_reg, sat_next;
    logic [clir_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [clir_pkg::DVD_W-1:0]         dvd_reg, dvd_next;
    logic [clir_pkg::DVS_W-1:0]         dvs_reg, dvs_next;
    logic [clir_pkg::DREM_W-1:0]        rem_reg, rem_next;
    logic [clir_pkg::DSH_W-1:0]         dsh_reg, dsh_next;
    logic [clir_pkg::QUOT_W-1:0]        quot_reg, quot_next;
    logic [clir_pkg::DREM_W-1:0]        dvs_top;
    logic                               ge;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        sat_next   = sat_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quot_next  = quot_reg;
        dvs_top    = {dvs_reg, {clir_pkg::QUOT_W{1'b0}}};
        ge         = rem_reg >= {1'b0, dsh_reg};

        case (state_reg)
            D_IDLE:
            begin
                // Take a new operand pair
                if (cmd.start)
                begin
                    dvd_next   = cmd.dividend;
                    dvs_next   = cmd.divisor;
                    state_next = D_CHECK;
                end
            end
            D_CHECK:
            begin
                // Quotient too wide to matter: flag saturation and stop
                if (dvd_reg >= clir_pkg::DVD_W'(dvs_top))
                begin
                    sat_next   = 1'b1;
                    quot_next  = '1;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    sat_next   = 1'b0;
                    quot_next  = '0;
                    rem_next   = dvd_reg[clir_pkg::DREM_W-1:0];
                    dsh_next   = {dvs_reg, {(clir_pkg::QUOT_W-1){1'b0}}};
                    cnt_next   = clir_pkg::DIV_CNT_W'(clir_pkg::QUOT_W);
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                // One trial subtract per cycle, divisor shifts down
                if (ge)
                begin
                    rem_next = rem_reg - {1'b0, dsh_reg};
                end
                quot_next = {quot_reg[clir_pkg::QUOT_W-2:0], ge};
                dsh_next  = dsh_reg >> 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == clir_pkg::DIV_CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg  <= sat_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
    assign stat.quot = quot_reg;

endmodule

`default_nettype wire

// ----- rtl/complex_linear_interp_resampler_top.sv -----
// Sequencer, configuration registers and item registers of the resampler.
// Depends on clir_pkg, clir_mac and clir_div.
//
// Source points come in one item at a time; each item yields zero to 64 sweep
// results, interpolated between the previous and the current source point. The
// block holds in_ready low while it works on an item. Each of the eight values
// of a result takes two passes through the shared multiplier and, unless the
// two points share a frequency, one pass through the shared divider; an item
// is set up first (sweep limit, result count division, sweep advance). An item
// that only opens a set is taken without leaving the idle state. The divider
// works at one quotient bit per cycle. A finished result waits in the output
// register while the next one is computed. There is no clearing pass after
// reset. The configuration port is always ready; write it only while no item
// is in progress.
`default_nettype none

module complex_linear_interp_resampler_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [clir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [clir_pkg::CFG_DATA_W-1:0]    cfg_data,
    // source points
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [clir_pkg::FREQ_W-1:0]        src_freq,
    input  wire logic signed [clir_pkg::VAL_W-1:0]  p0_re,
    input  wire logic signed [clir_pkg::VAL_W-1:0]  p0_im,
    input  wire logic signed [clir_pkg::VAL_W-1:0]  p1_re,
    input  wire logic signed [clir_pkg::VAL_W-1:0]  p1_im,
    input  wire logic signed [clir_pkg::VAL_W-1:0]  p2_re,
    input  wire logic signed [clir_pkg::VAL_W-1:0]  p2_im,
    input  wire logic signed [clir_pkg::VAL_W-1:0]  p3_re,
    input  wire logic signed [clir_pkg::VAL_W-1:0]  p3_im,
    input  wire logic                               last_point,
    // sweep results
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [clir_pkg::FREQ_W-1:0]             out_freq,
    output logic signed [clir_pkg::VAL_W-1:0]       q0_re,
    output logic signed [clir_pkg::VAL_W-1:0]       q0_im,
    output logic signed [clir_pkg::VAL_W-1:0]       q1_re,
    output logic signed [clir_pkg::VAL_W-1:0]       q1_im,
    output logic signed [clir_pkg::VAL_W-1:0]       q2_re,
    output logic signed [clir_pkg::VAL_W-1:0]       q2_im,
    output logic signed [clir_pkg::VAL_W-1:0]       q3_re,
    output logic signed [clir_pkg::VAL_W-1:0]       q3_im,
    output logic                                    last_result,
    output logic                                    overflow
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_LIMIT   = 12'b0000_0000_0010,
        S_RANGE   = 12'b0000_0000_0100,
        S_NDIV    = 12'b0000_0000_1000,
        S_NSCALE  = 12'b0000_0001_0000,
        S_ADVANCE = 12'b0000_0010_0000,
        S_MUL0    = 12'b0000_0100_0000,
        S_MUL1    = 12'b0000_1000_0000,
        S_DIVSET  = 12'b0001_0000_0000,
        S_DIVWAIT = 12'b0010_0000_0000,
        S_EMIT    = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } state_t;

    localparam int ADV_W = clir_pkg::COUNT_W + clir_pkg::FREQ_W + 1;

    // Control and persistent state
    state_t                             state_reg, state_next;
    logic [clir_pkg::FREQ_W-1:0]        start_reg, start_next;
    logic [clir_pkg::FREQ_W-1:0]        step_reg, step_next;
    logic [clir_pkg::FREQ_W-1:0]        stop_reg, stop_next;
    logic [clir_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [clir_pkg::FREQ_W-1:0]        prev_freq_reg, prev_freq_next;
    logic [clir_pkg::VAL_W-1:0]         prev_val_reg [clir_pkg::NUM_VALUES];
    logic [clir_pkg::VAL_W-1:0]         prev_val_next [clir_pkg::NUM_VALUES];
    logic                               have_prev_reg, have_prev_next;
    logic [clir_pkg::NEXT_W-1:0]        next_sweep_reg, next_sweep_next;
    logic [clir_pkg::COUNT_W-1:0]       emitted_reg, emitted_next;
    logic                               out_valid_reg, out_valid_next;

    // Item and working registers
    logic [clir_pkg::FREQ_W-1:0]        cur_freq_reg, cur_freq_next;
    logic [clir_pkg::VAL_W-1:0]         cur_val_reg [clir_pkg::NUM_VALUES];
    logic [clir_pkg::VAL_W-1:0]         cur_val_next [clir_pkg::NUM_VALUES];
    logic                               cur_last_reg, cur_last_next;
    logic [clir_pkg::FREQ_W-1:0]        lim_reg, lim_next;
    logic [clir_pkg::COUNT_W-1:0]       rem_reg, rem_next;
    logic [clir_pkg::NEXT_W-1:0]        d_reg, d_next;
    logic [clir_pkg::DVS_W-1:0]         ad_reg, ad_next;
    logic                               d_neg_reg, d_neg_next;
    logic                               d_zero_reg, d_zero_next;
    logic [clir_pkg::COUNT_W-1:0]       n_reg, n_next;
    logic [clir_pkg::RES_W-1:0]         nout_reg, nout_next;
    logic                               ovf_reg, ovf_next;
    logic [clir_pkg::RES_W-1:0]         k_reg, k_next;
    logic [clir_pkg::FREQ_W-1:0]        f_reg, f_next;
    logic [clir_pkg::VIDX_W-1:0]        vidx_reg, vidx_next;
    logic                               neg_res_reg, neg_res_next;
    logic [clir_pkg::VAL_W-1:0]         q_work_reg [clir_pkg::NUM_VALUES];
    logic [clir_pkg::VAL_W-1:0]         q_work_next [clir_pkg::NUM_VALUES];

    // Output register payload
    logic [clir_pkg::FREQ_W-1:0]        out_freq_reg, out_freq_next;
    logic [clir_pkg::VAL_W-1:0]         out_q_reg [clir_pkg::NUM_VALUES];
    logic [clir_pkg::VAL_W-1:0]         out_q_next [clir_pkg::NUM_VALUES];
    logic                               out_last_reg, out_last_next;
    logic                               out_ovf_reg, out_ovf_next;

    // Helpers
    logic [clir_pkg::VAL_W-1:0]         in_val [clir_pkg::NUM_VALUES];
    logic                               in_fire;
    logic                               out_free;
    logic [clir_pkg::FREQ_W-1:0]        step_eff;
    logic [clir_pkg::NEXT_W-1:0]        span;
    logic [clir_pkg::NEXT_W-1:0]        abs_d;
    logic [QUOT1_W-1:0]                 q_plus1;
    logic [clir_pkg::COUNT_W-1:0]       n_calc;
    logic [ADV_W-1:0]                   adv;
    logic                               acc_neg;
    logic [clir_pkg::DVD_W-1:0]         acc_mag;
    logic                               pos_sat;
    logic                               neg_sat;
    logic [clir_pkg::VAL_W-1:0]         q_sat;
    logic [clir_pkg::VAL_W-1:0]         y0_sel;
    logic [clir_pkg::VAL_W-1:0]         y1_sel;

    localparam int QUOT1_W = clir_pkg::QUOT_W + 1;

    logic signed [clir_pkg::ACC_W-1:0]  acc;
    clir_pkg::mac_op_t                  mac_op;
    clir_pkg::div_cmd_t                 div_cmd;
    clir_pkg::div_stat_t                div_stat;

    clir_mac u_mac (
        .clk (clk),
        .op  (mac_op),
        .acc (acc)
    );

    clir_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .stat  (div_stat)
    );

    // Gather the input values in field order
    assign in_val[0] = p0_re;
    assign in_val[1] = p0_im;
    assign in_val[2] = p1_re;
    assign in_val[3] = p1_im;
    assign in_val[4] = p2_re;
    assign in_val[5] = p2_im;
    assign in_val[6] = p3_re;
    assign in_val[7] = p3_im;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign step_eff  = (step_reg == '0) ? clir_pkg::FREQ_W'(1) : step_reg;

    // Datapath terms used by the sequencer
    always_comb
    begin
        span    = {1'b0, lim_reg} - next_sweep_reg;
        abs_d   = d_reg[clir_pkg::NEXT_W-1] ? (clir_pkg::NEXT_W'(0) - d_reg) : d_reg;
        q_plus1 = {1'b0, div_stat.quot} + 1'b1;
        if (div_stat.sat || (q_plus1 >= QUOT1_W'(rem_reg)))
        begin
            n_calc = rem_reg;
        end
        else
        begin
            n_calc = q_plus1[clir_pkg::COUNT_W-1:0];
        end
        adv     = ADV_W'(next_sweep_reg)
                + ADV_W'(acc[clir_pkg::COUNT_W+clir_pkg::FREQ_W-1:0]);
        acc_neg = acc[clir_pkg::ACC_W-1];
        acc_mag = clir_pkg::DVD_W'(ad_reg >> 1)
                + (acc_neg ? ~acc : acc)
                + clir_pkg::DVD_W'(acc_neg);
        pos_sat = div_stat.sat || (div_stat.quot > clir_pkg::QUOT_W'(clir_pkg::VAL_MAX));
        neg_sat = div_stat.sat
               || (div_stat.quot > clir_pkg::QUOT_W'({1'b0, clir_pkg::VAL_MIN}));
        if (neg_res_reg)
        begin
            q_sat = neg_sat ? clir_pkg::VAL_MIN
                            : (~div_stat.quot[clir_pkg::VAL_W-1:0] + 1'b1);
        end
        else
        begin
            q_sat = pos_sat ? clir_pkg::VAL_MAX : div_stat.quot[clir_pkg::VAL_W-1:0];
        end
        y0_sel = prev_val_reg[vidx_reg];
        y1_sel = cur_val_reg[vidx_reg];
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        start_next      = start_reg;
        step_next       = step_reg;
        stop_next       = stop_reg;
        count_next      = count_reg;
        prev_freq_next  = prev_freq_reg;
        prev_val_next   = prev_val_reg;
        have_prev_next  = have_prev_reg;
        next_sweep_next = next_sweep_reg;
        emitted_next    = emitted_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cur_freq_next   = cur_freq_reg;
        cur_val_next    = cur_val_reg;
        cur_last_next   = cur_last_reg;
        lim_next        = lim_reg;
        rem_next        = rem_reg;
        d_next          = d_reg;
        ad_next         = ad_reg;
        d_neg_next      = d_neg_reg;
        d_zero_next     = d_zero_reg;
        n_next          = n_reg;
        nout_next       = nout_reg;
        ovf_next        = ovf_reg;
        k_next          = k_reg;
        f_next          = f_reg;
        vidx_next       = vidx_reg;
        neg_res_next    = neg_res_reg;
        q_work_next     = q_work_reg;
        out_freq_next   = out_freq_reg;
        out_q_next      = out_q_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;
        mac_op          = '0;
        div_cmd         = '0;

        // Register writes
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                clir_pkg::REG_SWEEP_START: start_next = cfg_data;
                clir_pkg::REG_SWEEP_STEP:  step_next  = cfg_data;
                clir_pkg::REG_SWEEP_STOP:  stop_next  = cfg_data;
                clir_pkg::REG_SWEEP_COUNT: count_next = cfg_data[clir_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                // Take an item; a point that opens a set restarts the sweep
                if (in_fire)
                begin
                    cur_freq_next = src_freq;
                    cur_val_next  = in_val;
                    cur_last_next = last_point;
                    if (!have_prev_reg)
                    begin
                        prev_freq_next  = src_freq;
                        prev_val_next   = in_val;
                        next_sweep_next = {1'b0, start_reg};
                        emitted_next    = '0;
                        have_prev_next  = 1'b1;
                        if (last_point)
                        begin
                            state_next = S_LIMIT;
                        end
                    end
                    else
                    begin
                        state_next = S_LIMIT;
                    end
                end
            end
            S_LIMIT:
            begin
                // Sweep limit, points left in the set, and bracket width
                if (!cur_last_reg && (cur_freq_reg < stop_reg))
                begin
                    lim_next = cur_freq_reg;
                end
                else
                begin
                    lim_next = stop_reg;
                end
                rem_next   = (emitted_reg < count_reg) ? (count_reg - emitted_reg) : '0;
                d_next     = {1'b0, cur_freq_reg} - {1'b0, prev_freq_reg};
                state_next = S_RANGE;
            end
            S_RANGE:
            begin
                ad_next     = abs_d[clir_pkg::DVS_W-1:0];
                d_neg_next  = d_reg[clir_pkg::NEXT_W-1];
                d_zero_next = (d_reg == '0);
                if ((next_sweep_reg > {1'b0, lim_reg}) || (rem_reg == '0))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // Count sweep points up to the limit
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = clir_pkg::DVD_W'(span[clir_pkg::FREQ_W-1:0]);
                    div_cmd.divisor  = step_eff;
                    state_next       = S_NDIV;
                end
            end
            S_NDIV:
            begin
                if (div_stat.done)
                begin
                    n_next     = n_calc;
                    state_next = S_NSCALE;
                end
            end
            S_NSCALE:
            begin
                // Scale the count by the step for the sweep advance
                mac_op.en = 1'b1;
                mac_op.a  = {1'b0, n_reg};
                mac_op.b  = {1'b0, step_eff};
                if (n_reg > clir_pkg::COUNT_W'(clir_pkg::MAX_RESULTS))
                begin
                    nout_next = clir_pkg::RES_W'(clir_pkg::MAX_RESULTS);
                    ovf_next  = 1'b1;
                end
                else
                begin
                    nout_next = n_reg[clir_pkg::RES_W-1:0];
                    ovf_next  = 1'b0;
                end
                state_next = S_ADVANCE;
            end
            S_ADVANCE:
            begin
                // Advance the sweep past every point of this item, kept or dropped
                if (adv > ADV_W'(clir_pkg::SWEEP_END))
                begin
                    next_sweep_next = clir_pkg::SWEEP_END;
                end
                else
                begin
                    next_sweep_next = adv[clir_pkg::NEXT_W-1:0];
                end
                emitted_next = emitted_reg + n_reg;
                f_next       = next_sweep_reg[clir_pkg::FREQ_W-1:0];
                k_next       = '0;
                vidx_next    = '0;
                state_next   = S_MUL0;
            end
            S_MUL0:
            begin
                // y0 * (x1 - f)
                mac_op.en  = 1'b1;
                mac_op.a   = {y0_sel[clir_pkg::VAL_W-1], y0_sel};
                mac_op.b   = {1'b0, cur_freq_reg} - {1'b0, f_reg};
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                // add y1 * (f - x0)
                mac_op.en     = 1'b1;
                mac_op.acc_en = 1'b1;
                mac_op.a      = {y1_sel[clir_pkg::VAL_W-1], y1_sel};
                mac_op.b      = {1'b0, f_reg} - {1'b0, prev_freq_reg};
                state_next    = S_DIVSET;
            end
            S_DIVSET:
            begin
                if (d_zero_reg)
                begin
                    // Coincident points: take y0
                    q_work_next[vidx_reg] = y0_sel;
                    if (vidx_reg == clir_pkg::VIDX_W'(clir_pkg::ACTIVE_VALUES - 1))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        vidx_next  = vidx_reg + 1'b1;
                        state_next = S_MUL0;
                    end
                end
                else
                begin
                    // Rounded magnitude divide, sign applied afterward
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = acc_mag;
                    div_cmd.divisor  = ad_reg;
                    neg_res_next     = acc_neg ^ d_neg_reg;
                    state_next       = S_DIVWAIT;
                end
            end
            S_DIVWAIT:
            begin
                if (div_stat.done)
                begin
                    q_work_next[vidx_reg] = q_sat;
                    if (vidx_reg == clir_pkg::VIDX_W'(clir_pkg::ACTIVE_VALUES - 1))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        vidx_next  = vidx_reg + 1'b1;
                        state_next = S_MUL0;
                    end
                end
            end
            S_EMIT:
            begin
                // Hand the result over once the output register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_freq_next  = f_reg;
                    out_last_next  = (clir_pkg::RES_W'(k_reg + 1'b1) == nout_reg);
                    out_ovf_next   = ovf_reg;
                    for (int i = 0; i < clir_pkg::NUM_VALUES; i++)
                    begin
                        out_q_next[i] = (i < clir_pkg::ACTIVE_VALUES) ? q_work_reg[i] : '0;
                    end
                    if (clir_pkg::RES_W'(k_reg + 1'b1) == nout_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        f_next     = f_reg + step_eff;
                        vidx_next  = '0;
                        state_next = S_MUL0;
                    end
                end
            end
            S_DONE:
            begin
                // Current point becomes the lower end of the next bracket
                prev_freq_next = cur_freq_reg;
                prev_val_next  = cur_val_reg;
                have_prev_next = !cur_last_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            start_reg      <= clir_pkg::RST_SWEEP_START;
            step_reg       <= clir_pkg::RST_SWEEP_STEP;
            stop_reg       <= clir_pkg::RST_SWEEP_STOP;
            count_reg      <= clir_pkg::RST_SWEEP_COUNT;
            prev_freq_reg  <= '0;
            have_prev_reg  <= 1'b0;
            next_sweep_reg <= {1'b0, clir_pkg::RST_SWEEP_START};
            emitted_reg    <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < clir_pkg::NUM_VALUES; i++)
            begin
                prev_val_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            start_reg      <= start_next;
            step_reg       <= step_next;
            stop_reg       <= stop_next;
            count_reg      <= count_next;
            prev_freq_reg  <= prev_freq_next;
            have_prev_reg  <= have_prev_next;
            next_sweep_reg <= next_sweep_next;
            emitted_reg    <= emitted_next;
            out_valid_reg  <= out_valid_next;
            prev_val_reg   <= prev_val_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_freq_reg <= cur_freq_next;
        cur_val_reg  <= cur_val_next;
        cur_last_reg <= cur_last_next;
        lim_reg      <= lim_next;
        rem_reg      <= rem_next;
        d_reg        <= d_next;
        ad_reg       <= ad_next;
        d_neg_reg    <= d_neg_next;
        d_zero_reg   <= d_zero_next;
        n_reg        <= n_next;
        nout_reg     <= nout_next;
        ovf_reg      <= ovf_next;
        k_reg        <= k_next;
        f_reg        <= f_next;
        vidx_reg     <= vidx_next;
        neg_res_reg  <= neg_res_next;
        q_work_reg   <= q_work_next;
        out_freq_reg <= out_freq_next;
        out_q_reg    <= out_q_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_freq    = out_freq_reg;
    assign q0_re       = out_q_reg[0];
    assign q0_im       = out_q_reg[1];
    assign q1_re       = out_q_reg[2];
    assign q1_im       = out_q_reg[3];
    assign q2_re       = out_q_reg[4];
    assign q2_im       = out_q_reg[5];
    assign q3_re       = out_q_reg[6];
    assign q3_im       = out_q_reg[7];
    assign last_result = out_last_reg;
    assign overflow    = out_ovf_reg;

endmodule

`default_nettype wire

// ----- rtl/clir_checker.sv -----
// Port-level checks on the resampler top, attached by the bind at the end of this file.
// Depends on complex_linear_interp_resampler_top for the bind target.
`default_nettype none

module clir_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        last_point,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] out_freq,
    input wire logic [15:0] q0_re,
    input wire logic        last_result,
    input wire logic        overflow
);

    // A closing point always produces work, so the block goes busy
    property p_last_point_busy;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_point) |=> !in_ready;
    endproperty
    a_last_point_busy: assert property (p_last_point_busy)
        else $error("input still ready after a closing point was taken");

    // More results of the same item follow, so no new item is taken yet
    property p_more_results_busy;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_result) |=> !in_ready;
    endproperty
    a_more_results_busy: assert property (p_more_results_busy)
        else $error("input ready while results of an item are still due");

    // A new result only appears while an item is in progress
    property p_result_while_busy;
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready;
    endproperty
    a_result_while_busy: assert property (p_result_while_busy)
        else $error("result appeared while the block was idle");

    // Hold a stalled result
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_freq) && $stable(q0_re)
                                       && $stable(last_result) && $stable(overflow));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("stalled result dropped or changed");

endmodule

bind complex_linear_interp_resampler_top clir_checker u_clir_checker (.*);

`default_nettype wire

// ----- tb/sweep_checker.sv -----
// Scoreboard for the complex linear interpolation resampler: tracks register writes,
// predicts sweep results from accepted source points and compares every result.
// Depends on clir_pkg.
module sweep_checker
    import clir_pkg::*;
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [CFG_IDX_W-1:0]                 cfg_index,
    input  logic [CFG_DATA_W-1:0]                cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [FREQ_W-1:0]                    src_freq,
    input  logic [NUM_VALUES-1:0][VAL_W-1:0]     pt_vals,
    input  logic                                 last_point,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [FREQ_W-1:0]                    out_freq,
    input  logic [NUM_VALUES-1:0][VAL_W-1:0]     res_vals,
    input  logic                                 last_result,
    input  logic                                 overflow,
    output int                                   fail_count,
    output int                                   pending
);

    typedef struct packed {
        logic [FREQ_W-1:0]                freq;
        logic [NUM_VALUES-1:0][VAL_W-1:0] vals;
        logic                             is_last;
        logic                             ovf;
    } sweep_point_t;

    // Shadow copy of the sweep registers
    logic [FREQ_W-1:0]  reg_start;
    logic [FREQ_W-1:0]  reg_step;
    logic [FREQ_W-1:0]  reg_stop;
    logic [COUNT_W-1:0] reg_count;

    // Interpolation state: previous source point and sweep position
    logic [FREQ_W-1:0]                prev_freq;
    logic [NUM_VALUES-1:0][VAL_W-1:0] prev_vals;
    logic                             have_prev;
    logic [NEXT_W-1:0]                sweep_pos;
    logic [COUNT_W-1:0]               sweep_done;

    sweep_point_t expected_points[$];
    int           mismatches;

    // Interpolate one value between (x0,y0) and (x1,y1), round half away, saturate
    function automatic logic [VAL_W-1:0] lerp_value(input logic signed [VAL_W-1:0] y0, y1,
                                                   input logic [FREQ_W-1:0] x0, x1, f);
        longint sy0, sy1, sx0, sx1, sf, span, num, anum, aspan, quo;
        sy0 = y0;
        sy1 = y1;
        sx0 = x0;
        sx1 = x1;
        sf  = f;
        span = sx1 - sx0;
        if (span == 0)
            return y0;
        num   = sy0 * (sx1 - sf) + sy1 * (sf - sx0);
        anum  = (num < 0) ? -num : num;
        aspan = (span < 0) ? -span : span;
        quo   = (anum + aspan / 2) / aspan;
        if ((num < 0) != (span < 0))
            quo = -quo;
        if (quo > 32767)
            quo = 32767;
        if (quo < -32768)
            quo = -32768;
        return quo[VAL_W-1:0];
    endfunction

    // Advance the sweep for one source point and queue the results it causes
    function automatic void predict_point(input logic [FREQ_W-1:0] f1,
                                          input logic [NUM_VALUES-1:0][VAL_W-1:0] y1,
                                          input logic is_last);
        logic [63:0]  lim;
        logic [63:0]  n;
        logic [63:0]  rem;
        logic [63:0]  stp;
        logic [63:0]  adv;
        int           nout;
        sweep_point_t pt;
        // open a set: restart the sweep and hold the point
        if (!have_prev) begin
            sweep_pos  = NEXT_W'(reg_start);
            sweep_done = '0;
            prev_freq  = f1;
            prev_vals  = y1;
            have_prev  = 1'b1;
            if (!is_last)
                return;
        end
        stp = (reg_step == '0) ? 64'd1 : 64'(reg_step);
        lim = 64'(reg_stop);
        if (!is_last && f1 < reg_stop)
            lim = 64'(f1);
        if (64'(sweep_pos) > lim)
            n = 64'd0;
        else
            n = (lim - 64'(sweep_pos)) / stp + 64'd1;
        rem = (sweep_done < reg_count) ? 64'(reg_count - sweep_done) : 64'd0;
        if (n > rem)
            n = rem;
        nout = (n > MAX_RESULTS) ? MAX_RESULTS : int'(n);
        for (int k = 0; k < nout; k++) begin
            pt.freq = FREQ_W'(64'(sweep_pos) + 64'(k) * stp);
            for (int i = 0; i < NUM_VALUES; i++)
                pt.vals[i] = (i < ACTIVE_VALUES) ?
                    lerp_value(prev_vals[i], y1[i], prev_freq, f1, pt.freq) : '0;
            pt.is_last = (k == nout - 1);
            pt.ovf     = (n > MAX_RESULTS);
            expected_points.push_back(pt);
        end
        // dropped results still count and advance the sweep
        sweep_done = sweep_done + COUNT_W'(n);
        adv        = 64'(sweep_pos) + n * stp;
        sweep_pos  = (adv > 64'(SWEEP_END)) ? SWEEP_END : NEXT_W'(adv);
        prev_freq  = f1;
        prev_vals  = y1;
        have_prev  = !is_last;
    endfunction

    always @(posedge clk or negedge rst_n) begin : monitor
        sweep_point_t want;
        if (!rst_n) begin
            reg_start  = RST_SWEEP_START;
            reg_step   = RST_SWEEP_STEP;
            reg_stop   = RST_SWEEP_STOP;
            reg_count  = RST_SWEEP_COUNT;
            prev_freq  = '0;
            prev_vals  = '0;
            have_prev  = 1'b0;
            sweep_pos  = NEXT_W'(RST_SWEEP_START);
            sweep_done = '0;
            expected_points.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end else begin
            // track register writes; unknown indexes are ignored
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SWEEP_START: reg_start = cfg_data;
                    REG_SWEEP_STEP:  reg_step  = cfg_data;
                    REG_SWEEP_STOP:  reg_stop  = cfg_data;
                    REG_SWEEP_COUNT: reg_count = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                predict_point(src_freq, pt_vals, last_point);

            // compare each accepted result with the oldest prediction
            if (out_valid && out_ready) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual out_freq %0d",
                             $time, out_freq);
                    mismatches++;
                end else begin
                    want = expected_points.pop_front();
                    if (out_freq !== want.freq) begin
                        $display("%0t: out_freq expected %0d, actual %0d",
                                 $time, want.freq, out_freq);
                        mismatches++;
                    end
                    for (int i = 0; i < NUM_VALUES; i++) begin
                        if (res_vals[i] !== want.vals[i]) begin
                            $display("%0t: q%0d_%s at %0d kHz expected %0d, actual %0d",
                                     $time, i / 2, (i % 2) ? "im" : "re", want.freq,
                                     $signed(want.vals[i]), $signed(res_vals[i]));
                            mismatches++;
                        end
                    end
                    if (last_result !== want.is_last) begin
                        $display("%0t: last_result at %0d kHz expected %0b, actual %0b",
                                 $time, want.freq, want.is_last, last_result);
                        mismatches++;
                    end
                    if (overflow !== want.ovf) begin
                        $display("%0t: overflow at %0d kHz expected %0b, actual %0b",
                                 $time, want.freq, want.ovf, overflow);
                        mismatches++;
                    end
                end
            end
            fail_count <= mismatches;
            pending    <= expected_points.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the resampler regression: clock, reset, register programming and source points
// with random idling on both channels; the verdict comes from sweep_checker.
// Depends on clir_pkg, sweep_checker and complex_linear_interp_resampler_top.
module testbench;
    import clir_pkg::*;

    typedef logic [NUM_VALUES-1:0][VAL_W-1:0] value_set_t;

    localparam int ITEM_TARGET  = 330;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 5000000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [FREQ_W-1:0]     src_freq;
    value_set_t            pt_vals;
    logic                  last_point;
    logic                  out_valid;
    logic                  out_ready;
    logic [FREQ_W-1:0]     out_freq;
    wire  [NUM_VALUES-1:0][VAL_W-1:0] res_vals;
    logic                  last_result;
    logic                  overflow;

    int          fail_count;
    int          pending;
    int          items_sent;
    int          cycle_count = 0;
    logic        quiet;
    logic [31:0] cur_start;
    logic [31:0] cur_step;

    complex_linear_interp_resampler_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .src_freq    (src_freq),
        .p0_re       (pt_vals[0]),
        .p0_im       (pt_vals[1]),
        .p1_re       (pt_vals[2]),
        .p1_im       (pt_vals[3]),
        .p2_re       (pt_vals[4]),
        .p2_im       (pt_vals[5]),
        .p3_re       (pt_vals[6]),
        .p3_im       (pt_vals[7]),
        .last_point  (last_point),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_freq    (out_freq),
        .q0_re       (res_vals[0]),
        .q0_im       (res_vals[1]),
        .q1_re       (res_vals[2]),
        .q1_im       (res_vals[3]),
        .q2_re       (res_vals[4]),
        .q2_im       (res_vals[5]),
        .q3_re       (res_vals[6]),
        .q3_im       (res_vals[7]),
        .last_result (last_result),
        .overflow    (overflow)
    );

    sweep_checker u_sweep_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .src_freq    (src_freq),
        .pt_vals     (pt_vals),
        .last_point  (last_point),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_freq    (out_freq),
        .res_vals    (res_vals),
        .last_result (last_result),
        .overflow    (overflow),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("complex_linear_interp_resampler_top regression: fail");
            $finish;
        end
    end

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 250);
    endfunction

    // Parameter set biased toward the Q1.15 extremes
    function automatic value_set_t pick_vals();
        value_set_t v;
        int         r;
        for (int i = 0; i < NUM_VALUES; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                v[i] = VAL_MAX;
            else if (r < 20)
                v[i] = VAL_MIN;
            else if (r < 25)
                v[i] = '0;
            else
                v[i] = VAL_W'($urandom);
        end
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_sweep(input logic [31:0] start_khz, step_khz, stop_khz,
                                 count_word);
        write_reg(REG_SWEEP_START, start_khz);
        write_reg(REG_SWEEP_STEP, step_khz);
        write_reg(REG_SWEEP_STOP, stop_khz);
        write_reg(REG_SWEEP_COUNT, count_word);
        cur_start = start_khz;
        cur_step  = step_khz;
    endtask

    // Offer one source point; hold valid until accepted, then maybe idle
    task automatic send_point(input logic [31:0] f, input value_set_t v, input logic lp);
        int gap;
        src_freq   <= f;
        pt_vals    <= v;
        last_point <= lp;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid, wait for every predicted result, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: accept with random stalls
    initial begin
        int hold;
        out_ready <= 1'b0;
        hold = 0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                out_ready <= 1'b0;
                hold--;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    hold = pick_gap();
            end
        end
    end

    initial begin
        int          r;
        int          len;
        int          kind;
        logic [31:0] new_start;
        logic [31:0] new_step;
        logic [31:0] new_stop;
        logic [15:0] new_count;
        logic [63:0] f;
        logic [63:0] stp;
        logic [63:0] base;

        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        src_freq   <= '0;
        pt_vals    <= '0;
        last_point <= 1'b0;
        quiet      = 1'b0;
        items_sent = 0;
        cur_start  = RST_SWEEP_START;
        cur_step   = RST_SWEEP_STEP;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: the closing point runs into the 64-result cut
        send_point(32'd0, pick_vals(), 1'b0);
        send_point(32'd3, pick_vals(), 1'b1);
        wait_idle();

        // Extrapolate below the first pair with saturation, then a descending last point
        program_sweep(32'd1000, 32'd100, 32'hFFFF_FFFF, 32'd12);
        write_reg(8'hFF, 32'hFFFF_FFFF);
        write_reg(8'd4, 32'h0000_0000);
        send_point(32'd1050, {NUM_VALUES{VAL_MAX}}, 1'b0);
        send_point(32'd1200, {NUM_VALUES{VAL_MIN}}, 1'b0);
        send_point(32'd1100, pick_vals(), 1'b1);
        // equal frequencies, then a single-point set
        send_point(32'd2000, pick_vals(), 1'b0);
        send_point(32'd2000, pick_vals(), 1'b0);
        send_point(32'd2500, pick_vals(), 1'b1);
        send_point(32'd700, pick_vals(), 1'b1);
        wait_idle();

        // Zero step acts as one; the count of 100 caps the 201 points of one item, which still overflow
        program_sweep(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd100);
        send_point(32'd0, pick_vals(), 1'b0);
        send_point(32'd200, pick_vals(), 1'b0);
        send_point(32'd300, pick_vals(), 1'b1);
        wait_idle();

        // Count of zero emits nothing, count of one a single point
        program_sweep(32'd0, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_0000);
        send_point(32'd10, pick_vals(), 1'b0);
        send_point(32'd20, pick_vals(), 1'b1);
        wait_idle();
        write_reg(REG_SWEEP_COUNT, 32'd1);
        send_point(32'd10, pick_vals(), 1'b0);
        send_point(32'd20, pick_vals(), 1'b1);
        wait_idle();

        // Sweep runs past the top of the frequency range and saturates
        program_sweep(32'hFFFF_FF00, 32'h0000_00A0, 32'hFFFF_FFFF, 32'h0000_FFFF);
        send_point(32'hFFFF_FE00, pick_vals(), 1'b0);
        send_point(32'hFFFF_FFA0, pick_vals(), 1'b0);
        send_point(32'hFFFF_FFFF, pick_vals(), 1'b1);
        wait_idle();
        program_sweep(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2);
        send_point(32'hFFFF_FFFF, {NUM_VALUES{VAL_MIN}}, 1'b1);
        wait_idle();

        // Stop frequency cuts the sweep short; stop at zero
        program_sweep(32'd100, 32'd10, 32'd150, 32'd1601);
        send_point(32'd0, pick_vals(), 1'b0);
        send_point(32'd120, pick_vals(), 1'b0);
        send_point(32'd400, pick_vals(), 1'b1);
        wait_idle();
        program_sweep(32'd0, 32'd7, 32'd0, 32'd5);
        send_point(32'd0, pick_vals(), 1'b1);
        wait_idle();

        // Random phases: new settings, then a few sets
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                new_start = $urandom_range(0, 100000);
            else if (r < 85)
                new_start = $urandom;
            else if (r < 93)
                new_start = 32'hFFFF_FFFF - $urandom_range(0, 4000);
            else
                new_start = 32'd0;
            r = $urandom_range(0, 99);
            if (r < 70)
                new_step = $urandom_range(1, 5000);
            else if (r < 80)
                new_step = 32'd0;
            else if (r < 90)
                new_step = $urandom;
            else
                new_step = 32'hFFFF_FFFF;
            r = $urandom_range(0, 99);
            if (r < 72)
                new_count = $urandom_range(2, 24);
            else if (r < 84)
                new_count = $urandom_range(0, 1);
            else if (r < 94)
                new_count = $urandom_range(25, 70);
            else
                new_count = 16'hFFFF;
            stp = (new_step == 0) ? 64'd1 : 64'(new_step);
            r = $urandom_range(0, 99);
            if (new_count == 16'hFFFF || (r >= 55 && r < 85)) begin
                // keep the stop a bounded number of steps past the start
                f = 64'(new_start) + stp * 64'($urandom_range(0, 100));
                new_stop = (f > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : f[31:0];
            end else if (r < 55) begin
                new_stop = 32'hFFFF_FFFF;
            end else begin
                new_stop = $urandom;
            end
            program_sweep(new_start, new_step, new_stop,
                          {16'($urandom_range(0, 65535)), new_count});
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(4, 255)), $urandom);
            quiet = ($urandom_range(0, 5) == 0);

            repeat ($urandom_range(2, 5)) begin
                kind = $urandom_range(0, 99);
                stp  = (cur_step == 0) ? 64'd1 : 64'(cur_step);
                if (kind < 75) begin
                    // well-formed set: ascending points spaced a few steps apart
                    len  = $urandom_range(1, 8);
                    base = 64'($urandom_range(0, 2)) * stp;
                    f    = (64'(cur_start) > base) ? 64'(cur_start) - base : 64'd0;
                    f    = f + 64'($urandom_range(0, 9));
                    for (int k = 0; k < len; k++) begin
                        if (k > 0)
                            f = f + 64'($urandom_range(0, 3)) * stp + 64'($urandom_range(0, 9));
                        if (f > 64'hFFFF_FFFF)
                            f = 64'hFFFF_FFFF;
                        send_point(f[31:0], pick_vals(), k == len - 1);
                    end
                end else begin
                    // broken set: random, repeated and descending frequencies
                    len = $urandom_range(1, 5);
                    f   = ($urandom_range(0, 1) == 1) ? 64'($urandom) : 64'(cur_start);
                    for (int k = 0; k < len; k++) begin
                        if (k > 0) begin
                            r = $urandom_range(0, 99);
                            if (r < 40)
                                f = 64'($urandom);
                            else if (r >= 70)
                                f = f + 64'($urandom_range(0, 5000));
                            else if (r >= 50)
                                f = (f > 64'd5000) ? f - 64'($urandom_range(0, 5000)) : 64'd0;
                        end
                        if (f > 64'hFFFF_FFFF)
                            f = 64'hFFFF_FFFF;
                        send_point(f[31:0], pick_vals(), k == len - 1);
                    end
                end
            end
            wait_idle();
        end

        if (fail_count == 0 && pending == 0)
            $display("complex_linear_interp_resampler_top regression: pass");
        else
            $display("complex_linear_interp_resampler_top regression: fail");
        $finish;
    end

endmodule
